// File: sv/ppl_pkg.sv
`timescale 1ns / 1ps

package ppl_pkg;

    localparam int unsigned DEF_LIST_DEPTH  = 16;
    localparam int unsigned DEF_VALUE_WIDTH = 32;
    localparam int unsigned DEF_KEY_WIDTH   = 32;

    localparam int unsigned OPCODE_W = 3;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_LOOKUP = 3'd3,
        OP_UPDATE = 3'd4,
        OP_READ   = 3'd5
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

endpackage

// File: sv/positional_pair_list_core.sv
`timescale 1ns / 1ps

// Bounded gap-free list of value/key pairs held in a single-port-read,
// single-port-write RAM with a registered read. One request is worked on at
// a time; the result sits in an output register while the next request is
// taken, unless an earlier result still waits for that register. Append and
// insert move each entry from the end down to the position up one place, a
// read state then a write-back state per entry; remove fetches the entry and
// moves each later entry down the same way; read only fetches; lookup and
// update scan from entry 0, a read then a compare per entry, and update
// writes at the first hit. Errors and unused opcodes go straight to reply.

module positional_pair_list_core #(
    parameter int unsigned LIST_DEPTH  = ppl_pkg::DEF_LIST_DEPTH,
    parameter int unsigned VALUE_WIDTH = ppl_pkg::DEF_VALUE_WIDTH,
    parameter int unsigned KEY_WIDTH   = ppl_pkg::DEF_KEY_WIDTH,
    localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
    localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  logic [ppl_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [VALUE_WIDTH-1:0]        i_value_in,
    input  logic [KEY_WIDTH-1:0]          i_key_in,
    input  logic [IDX_W-1:0]              i_position,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    output logic [ppl_pkg::STATUS_W-1:0]  o_status,
    output logic [VALUE_WIDTH-1:0]        o_value_out,
    output logic [KEY_WIDTH-1:0]          o_key_out,
    output logic [CNT_W-1:0]              o_entry_count
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_SHIFT_UP_WR,
        S_FETCH,
        S_SHIFT_DN,
        S_SHIFT_DN_WR,
        S_SCAN,
        S_SCAN_CMP,
        S_RESP
    } t_state;

    t_state              r_state;
    ppl_pkg::t_opcode    r_op;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [CNT_W-1:0]    r_pos;
    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_count;

    ppl_pkg::t_status    r_res_status;
    logic [VALUE_WIDTH-1:0] r_res_val;
    logic [KEY_WIDTH-1:0]   r_res_key;

    logic                r_o_valid;
    ppl_pkg::t_status    r_o_status;
    logic [VALUE_WIDTH-1:0] r_o_value;
    logic [KEY_WIDTH-1:0]   r_o_key;
    logic [CNT_W-1:0]    r_o_count;

    ppl_pkg::t_opcode    w_op;
    logic [CNT_W-1:0]    w_pos_in;
    logic [CNT_W-1:0]    w_idx_m1;
    logic [CNT_W-1:0]    w_idx_p1;
    logic                w_accept;
    logic                w_out_free;
    logic                w_hit;

    logic                w_we;
    logic [CNT_W-1:0]    w_waddr;
    logic [VALUE_WIDTH-1:0] w_wvalue;
    logic [KEY_WIDTH-1:0]   w_wkey;
    logic                w_re;
    logic [CNT_W-1:0]    w_raddr;
    logic [VALUE_WIDTH-1:0] w_rvalue;
    logic [KEY_WIDTH-1:0]   w_rkey;

    assign w_op       = ppl_pkg::t_opcode'(i_opcode);
    assign w_pos_in   = CNT_W'(i_position);
    assign w_idx_m1   = r_idx - 1'b1;
    assign w_idx_p1   = r_idx + 1'b1;
    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept   = i_req_valid && o_req_ready;
    assign w_out_free = !r_o_valid || i_rsp_ready;
    assign w_hit      = (w_rkey == r_key);

    always_comb begin
        w_we     = 1'b0;
        w_waddr  = r_idx;
        w_wvalue = w_rvalue;
        w_wkey   = w_rkey;
        w_re     = 1'b0;
        w_raddr  = r_idx;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (w_op == ppl_pkg::OP_REMOVE || w_op == ppl_pkg::OP_READ)
                    && w_pos_in < r_count) begin
                    w_re    = 1'b1;
                    w_raddr = w_pos_in;
                end
            end
            S_SHIFT_UP: begin
                if (r_idx == r_pos) begin
                    w_we     = 1'b1;
                    w_waddr  = r_pos;
                    w_wvalue = r_val;
                    w_wkey   = r_key;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = w_idx_m1;
                end
            end
            S_SHIFT_UP_WR: w_we = 1'b1;
            S_SHIFT_DN: begin
                if (w_idx_p1 < r_count) begin
                    w_re    = 1'b1;
                    w_raddr = w_idx_p1;
                end
            end
            S_SHIFT_DN_WR: w_we = 1'b1;
            S_SCAN: w_re = (r_idx < r_count);
            S_SCAN_CMP: begin
                if (w_hit && r_op == ppl_pkg::OP_UPDATE) begin
                    w_we     = 1'b1;
                    w_wvalue = r_val;
                end
            end
            default: ;
        endcase
    end

    ppl_store #(
        .DEPTH   (LIST_DEPTH),
        .VALUE_W (VALUE_WIDTH),
        .KEY_W   (KEY_WIDTH),
        .ADDR_W  (IDX_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr[IDX_W-1:0]),
        .i_wvalue (w_wvalue),
        .i_wkey   (w_wkey),
        .i_re     (w_re),
        .i_raddr  (w_raddr[IDX_W-1:0]),
        .o_rvalue (w_rvalue),
        .o_rkey   (w_rkey)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_rsp_ready && r_state != S_RESP) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op         <= w_op;
                        r_val        <= i_value_in;
                        r_key        <= i_key_in;
                        r_res_status <= ppl_pkg::ST_OK;
                        r_res_val    <= '0;
                        r_res_key    <= '0;
                        r_idx        <= '0;
                        r_state      <= S_RESP;
                        case (w_op)
                            ppl_pkg::OP_APPEND, ppl_pkg::OP_INSERT: begin
                                r_pos <= (w_op == ppl_pkg::OP_APPEND) ? r_count : w_pos_in;
                                r_idx <= r_count;
                                if (r_count >= CNT_W'(LIST_DEPTH)) begin
                                    r_res_status <= ppl_pkg::ST_FULL;
                                end else if (w_op == ppl_pkg::OP_INSERT
                                             && w_pos_in > r_count) begin
                                    r_res_status <= ppl_pkg::ST_RANGE;
                                end else begin
                                    r_state <= S_SHIFT_UP;
                                end
                            end
                            ppl_pkg::OP_REMOVE, ppl_pkg::OP_READ: begin
                                r_pos <= w_pos_in;
                                r_idx <= w_pos_in;
                                if (w_pos_in < r_count) begin
                                    r_state <= S_FETCH;
                                end else begin
                                    r_res_status <= ppl_pkg::ST_RANGE;
                                end
                            end
                            ppl_pkg::OP_LOOKUP, ppl_pkg::OP_UPDATE: r_state <= S_SCAN;
                            default: ;
                        endcase
                    end
                end
                S_SHIFT_UP: begin
                    if (r_idx == r_pos) begin
                        r_count   <= r_count + 1'b1;
                        r_res_val <= r_val;
                        r_res_key <= r_key;
                        r_state   <= S_RESP;
                    end else begin
                        r_state <= S_SHIFT_UP_WR;
                    end
                end
                S_SHIFT_UP_WR: begin
                    r_idx   <= w_idx_m1;
                    r_state <= S_SHIFT_UP;
                end
                S_FETCH: begin
                    r_res_val <= w_rvalue;
                    r_res_key <= w_rkey;
                    r_state   <= (r_op == ppl_pkg::OP_REMOVE) ? S_SHIFT_DN : S_RESP;
                end
                S_SHIFT_DN: begin
                    if (w_idx_p1 < r_count) begin
                        r_state <= S_SHIFT_DN_WR;
                    end else begin
                        r_count <= r_count - 1'b1;
                        r_state <= S_RESP;
                    end
                end
                S_SHIFT_DN_WR: begin
                    r_idx   <= w_idx_p1;
                    r_state <= S_SHIFT_DN;
                end
                S_SCAN: begin
                    if (r_idx < r_count) begin
                        r_state <= S_SCAN_CMP;
                    end else begin
                        r_res_status <= ppl_pkg::ST_NOT_FOUND;
                        r_state      <= S_RESP;
                    end
                end
                S_SCAN_CMP: begin
                    if (w_hit) begin
                        r_res_val <= (r_op == ppl_pkg::OP_UPDATE) ? r_val : w_rvalue;
                        r_res_key <= w_rkey;
                        r_state   <= S_RESP;
                    end else begin
                        r_idx   <= w_idx_p1;
                        r_state <= S_SCAN;
                    end
                end
                S_RESP: begin
                    if (w_out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_res_status;
                        r_o_value  <= r_res_val;
                        r_o_key    <= r_res_key;
                        r_o_count  <= r_count;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp_valid   = r_o_valid;
    assign o_status      = r_o_status;
    assign o_value_out   = r_o_value;
    assign o_key_out     = r_o_key;
    assign o_entry_count = r_o_count;

endmodule

// File: sv/ppl_store.sv
`timescale 1ns / 1ps

module ppl_store #(
    parameter int unsigned DEPTH   = ppl_pkg::DEF_LIST_DEPTH,
    parameter int unsigned VALUE_W = ppl_pkg::DEF_VALUE_WIDTH,
    parameter int unsigned KEY_W   = ppl_pkg::DEF_KEY_WIDTH,
    parameter int unsigned ADDR_W  = 4
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [ADDR_W-1:0]  i_waddr,
    input  logic [VALUE_W-1:0] i_wvalue,
    input  logic [KEY_W-1:0]   i_wkey,
    input  logic               i_re,
    input  logic [ADDR_W-1:0]  i_raddr,
    output logic [VALUE_W-1:0] o_rvalue,
    output logic [KEY_W-1:0]   o_rkey
);

    logic [VALUE_W-1:0] r_value_mem [DEPTH];
    logic [KEY_W-1:0]   r_key_mem   [DEPTH];
    logic [VALUE_W-1:0] r_rvalue;
    logic [KEY_W-1:0]   r_rkey;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_value_mem[i_waddr] <= i_wvalue;
            r_key_mem[i_waddr]   <= i_wkey;
        end
        if (i_re) begin
            r_rvalue <= r_value_mem[i_raddr];
            r_rkey   <= r_key_mem[i_raddr];
        end
    end

    assign o_rvalue = r_rvalue;
    assign o_rkey   = r_rkey;

endmodule

// File: dv/ppl_checker.sv
`timescale 1ns / 1ps

module ppl_checker #(
    parameter int unsigned LIST_DEPTH  = ppl_pkg::DEF_LIST_DEPTH,
    parameter int unsigned VALUE_WIDTH = ppl_pkg::DEF_VALUE_WIDTH,
    parameter int unsigned KEY_WIDTH   = ppl_pkg::DEF_KEY_WIDTH,
    localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
    localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    input  logic                             i_req_ready,
    input  logic [ppl_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [VALUE_WIDTH-1:0]           i_value_in,
    input  logic [KEY_WIDTH-1:0]             i_key_in,
    input  logic [IDX_W-1:0]                 i_position,
    input  logic                             i_rsp_valid,
    input  logic                             i_rsp_ready,
    input  logic [ppl_pkg::STATUS_W-1:0]     i_status,
    input  logic [VALUE_WIDTH-1:0]           i_value_out,
    input  logic [KEY_WIDTH-1:0]             i_key_out,
    input  logic [CNT_W-1:0]                 i_entry_count,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked
);

    typedef struct packed {
        ppl_pkg::t_status       status;
        logic [VALUE_WIDTH-1:0] value;
        logic [KEY_WIDTH-1:0]   key;
        logic [CNT_W-1:0]       count;
    } t_list_rsp;

    logic [VALUE_WIDTH-1:0] list_val [LIST_DEPTH];
    logic [KEY_WIDTH-1:0]   list_key [LIST_DEPTH];
    int                     list_len;
    t_list_rsp              list_rsp_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        list_len     = 0;
    end

    task automatic note_fail(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // One request against the list copy; returns the response it must produce.
    task automatic run_list_op(
        input  logic [ppl_pkg::OPCODE_W-1:0] op,
        input  logic [VALUE_WIDTH-1:0]       v,
        input  logic [KEY_WIDTH-1:0]         k,
        input  logic [IDX_W-1:0]             p,
        output t_list_rsp                    r
    );
        int at;
        int hit;
        r = '0;
        r.status = ppl_pkg::ST_OK;
        case (op)
            ppl_pkg::OP_APPEND, ppl_pkg::OP_INSERT: begin
                at = (op == ppl_pkg::OP_APPEND) ? list_len : int'(p);
                if (list_len >= LIST_DEPTH) begin
                    r.status = ppl_pkg::ST_FULL;
                end else if (at > list_len) begin
                    r.status = ppl_pkg::ST_RANGE;
                end else begin
                    for (int i = list_len; i > at; i--) begin
                        list_val[i] = list_val[i-1];
                        list_key[i] = list_key[i-1];
                    end
                    list_val[at] = v;
                    list_key[at] = k;
                    list_len++;
                    r.value = v;
                    r.key   = k;
                end
            end
            ppl_pkg::OP_REMOVE: begin
                if (int'(p) >= list_len) begin
                    r.status = ppl_pkg::ST_RANGE;
                end else begin
                    r.value = list_val[p];
                    r.key   = list_key[p];
                    for (int i = int'(p); i + 1 < list_len; i++) begin
                        list_val[i] = list_val[i+1];
                        list_key[i] = list_key[i+1];
                    end
                    list_len--;
                end
            end
            ppl_pkg::OP_LOOKUP, ppl_pkg::OP_UPDATE: begin
                hit = -1;
                for (int i = 0; i < list_len; i++) begin
                    if (hit < 0 && list_key[i] == k) begin
                        hit = i;
                    end
                end
                if (hit < 0) begin
                    r.status = ppl_pkg::ST_NOT_FOUND;
                end else begin
                    if (op == ppl_pkg::OP_UPDATE) begin
                        list_val[hit] = v;
                    end
                    r.value = list_val[hit];
                    r.key   = list_key[hit];
                end
            end
            ppl_pkg::OP_READ: begin
                if (int'(p) >= list_len) begin
                    r.status = ppl_pkg::ST_RANGE;
                end else begin
                    r.value = list_val[p];
                    r.key   = list_key[p];
                end
            end
            default: begin
            end
        endcase
        r.count = list_len[CNT_W-1:0];
    endtask

    always @(posedge i_clk) begin
        t_list_rsp want;
        if (!i_rst_n) begin
            list_len = 0;
            list_rsp_q.delete();
        end else begin
            if (i_req_valid && i_req_ready) begin
                run_list_op(i_opcode, i_value_in, i_key_in, i_position, want);
                list_rsp_q.insert(list_rsp_q.size(), want);
            end
            if (i_rsp_valid && i_rsp_ready) begin
                o_checked++;
                if (list_rsp_q.size() == 0) begin
                    note_fail($sformatf(
                        "response with no request outstanding: %s %0d %s %h %s %h %s %0d",
                        "status", i_status, "value", i_value_out,
                        "key", i_key_out, "count", i_entry_count));
                end else begin
                    want = list_rsp_q.pop_front();
                    if (i_status !== want.status || i_value_out !== want.value
                            || i_key_out !== want.key || i_entry_count !== want.count) begin
                        note_fail($sformatf(
                            {"exp status %0d value %h key %h count %0d, ",
                             "got status %0d value %h key %h count %0d"},
                            want.status, want.value, want.key, want.count,
                            i_status, i_value_out, i_key_out, i_entry_count));
                    end
                end
            end
        end
        o_pending = list_rsp_q.size();
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned IDX_W = $clog2(ppl_pkg::DEF_LIST_DEPTH);
    localparam int unsigned CNT_W = $clog2(ppl_pkg::DEF_LIST_DEPTH + 1);
    localparam int unsigned VW    = ppl_pkg::DEF_VALUE_WIDTH;
    localparam int unsigned KW    = ppl_pkg::DEF_KEY_WIDTH;
    localparam int unsigned OW    = ppl_pkg::OPCODE_W;
    localparam logic [OW-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OW-1:0] OP_SPARE_B = 3'd7;
    localparam int RANDOM_REQS  = 1220;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 80;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_req_valid;
    logic                           o_req_ready;
    logic [OW-1:0]                  i_opcode;
    logic [VW-1:0]                  i_value_in;
    logic [KW-1:0]                  i_key_in;
    logic [IDX_W-1:0]               i_position;
    logic                           o_rsp_valid;
    logic                           i_rsp_ready;
    logic [ppl_pkg::STATUS_W-1:0]   o_status;
    logic [VW-1:0]                  o_value_out;
    logic [KW-1:0]                  o_key_out;
    logic [CNT_W-1:0]               o_entry_count;

    int fail_count;
    int pending;
    int checked;
    int cycles;
    int op_sent [8];
    bit req_calm;
    bit rsp_calm;
    logic [KW-1:0] key_pool [6];

    positional_pair_list_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req_valid),
        .o_req_ready   (o_req_ready),
        .i_opcode      (i_opcode),
        .i_value_in    (i_value_in),
        .i_key_in      (i_key_in),
        .i_position    (i_position),
        .o_rsp_valid   (o_rsp_valid),
        .i_rsp_ready   (i_rsp_ready),
        .o_status      (o_status),
        .o_value_out   (o_value_out),
        .o_key_out     (o_key_out),
        .o_entry_count (o_entry_count)
    );

    ppl_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req_valid),
        .i_req_ready   (o_req_ready),
        .i_opcode      (i_opcode),
        .i_value_in    (i_value_in),
        .i_key_in      (i_key_in),
        .i_position    (i_position),
        .i_rsp_valid   (o_rsp_valid),
        .i_rsp_ready   (i_rsp_ready),
        .i_status      (o_status),
        .i_value_out   (o_value_out),
        .i_key_out     (o_key_out),
        .i_entry_count (o_entry_count),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d requests outstanding", cycles, pending);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 2);
        end else if (r < 95) begin
            return $urandom_range(3, 6);
        end
        return $urandom_range(20, 60);
    endfunction

    // Response side: ready drops at random unless in a calm stretch.
    initial begin
        int stall_left;
        stall_left = 0;
        i_rsp_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_rsp_ready <= 1'b0;
                stall_left--;
            end else begin
                i_rsp_ready <= 1'b1;
                if (!rsp_calm && $urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    function automatic logic [OW-1:0] pick_op(input int kind);
        int r;
        int c_app, c_ins, c_rem, c_look, c_upd, c_rd;
        r = $urandom_range(0, 99);
        case (kind)
            0: begin
                c_app = 35; c_ins = 65; c_rem = 72; c_look = 80; c_upd = 88; c_rd = 97;
            end
            1: begin
                c_app = 10; c_ins = 20; c_rem = 55; c_look = 67; c_upd = 79; c_rd = 97;
            end
            default: begin
                c_app = 18; c_ins = 36; c_rem = 54; c_look = 68; c_upd = 82; c_rd = 97;
            end
        endcase
        if (r < c_app)  return ppl_pkg::OP_APPEND;
        if (r < c_ins)  return ppl_pkg::OP_INSERT;
        if (r < c_rem)  return ppl_pkg::OP_REMOVE;
        if (r < c_look) return ppl_pkg::OP_LOOKUP;
        if (r < c_upd)  return ppl_pkg::OP_UPDATE;
        if (r < c_rd)   return ppl_pkg::OP_READ;
        if (r < 99)     return OP_SPARE_A;
        return OP_SPARE_B;
    endfunction

    function automatic logic [VW-1:0] rand_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    function automatic logic [KW-1:0] rand_key();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return key_pool[$urandom_range(0, 5)];
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_req(
        input logic [OW-1:0]    op,
        input logic [VW-1:0]    v,
        input logic [KW-1:0]    k,
        input logic [IDX_W-1:0] p
    );
        i_opcode    <= op;
        i_value_in  <= v;
        i_key_in    <= k;
        i_position  <= p;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        op_sent[op]++;
        @(negedge i_clk);
    endtask

    task automatic idle_after();
        int gap;
        gap = (req_calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain_all();
        i_req_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        @(negedge i_clk);
    endtask

    initial begin
        int kind;
        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_opcode    = ppl_pkg::OP_APPEND;
        i_value_in  = '0;
        i_key_in    = '0;
        i_position  = '0;
        req_calm    = 1'b0;
        rsp_calm    = 1'b0;
        foreach (op_sent[i]) op_sent[i] = 0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 6; i++) key_pool[i] = $urandom;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty list, edges of the fields, shifting, first match, full list
        send_req(ppl_pkg::OP_REMOVE, '1, '1, '0);                       idle_after();
        send_req(ppl_pkg::OP_LOOKUP, '0, '0, '0);                       idle_after();
        send_req(OP_SPARE_A, '1, '1, '1);                               idle_after();
        send_req(OP_SPARE_B, '1, '1, '1);                               idle_after();
        send_req(ppl_pkg::OP_APPEND, '0, '0, '1);                       idle_after();
        send_req(ppl_pkg::OP_APPEND, '1, '1, '0);                       idle_after();
        send_req(ppl_pkg::OP_INSERT, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 4'd0); idle_after();
        send_req(ppl_pkg::OP_INSERT, 32'h1234_5678, key_pool[2], 4'd3);   idle_after();
        send_req(ppl_pkg::OP_INSERT, $urandom, $urandom, 4'd5);         idle_after();
        send_req(ppl_pkg::OP_APPEND, 32'hCAFE_0001, '0, 4'd9);          idle_after();
        send_req(ppl_pkg::OP_LOOKUP, '1, '0, '0);                       idle_after();
        send_req(ppl_pkg::OP_UPDATE, 32'h0BAD_F00D, '1, '0);            idle_after();
        send_req(ppl_pkg::OP_UPDATE, $urandom, 32'h7777_7777, '0);      idle_after();
        send_req(ppl_pkg::OP_REMOVE, '0, '0, 4'd1);                     idle_after();
        send_req(ppl_pkg::OP_READ, '0, '0, 4'd0);                       idle_after();
        for (int i = 0; i < 12; i++) begin
            send_req(ppl_pkg::OP_INSERT, rand_value(), rand_key(), '0);
            idle_after();
        end
        send_req(ppl_pkg::OP_APPEND, '1, '1, '0);                       idle_after();
        send_req(ppl_pkg::OP_INSERT, '1, '1, '0);                       idle_after();
        send_req(ppl_pkg::OP_REMOVE, '0, '0, '1);                       idle_after();
        send_req(ppl_pkg::OP_READ, '0, '0, '1);                         idle_after();
        send_req(ppl_pkg::OP_REMOVE, '0, '0, '0);
        drain_all();

        kind = 0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 100 == 0) begin
                kind     = $urandom_range(0, 2);
                req_calm = ($urandom_range(0, 3) == 0);
                rsp_calm = ($urandom_range(0, 3) == 0);
            end
            if (n == RANDOM_REQS / 2) begin
                drain_all();
            end
            send_req(pick_op(kind), rand_value(), rand_key(),
                     ($urandom_range(0, 1) != 0) ? IDX_W'($urandom_range(0, 15))
                                                 : IDX_W'($urandom_range(0, 5)));
            idle_after();
        end

        i_req_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d append, %0d insert, %0d remove, %0d lookup, %0d update,",
                 op_sent[ppl_pkg::OP_APPEND], op_sent[ppl_pkg::OP_INSERT],
                 op_sent[ppl_pkg::OP_REMOVE], op_sent[ppl_pkg::OP_LOOKUP],
                 op_sent[ppl_pkg::OP_UPDATE]);
        $display("%0d read and %0d spare-opcode requests; %0d responses compared in %0d cycles.",
                 op_sent[ppl_pkg::OP_READ], op_sent[OP_SPARE_A] + op_sent[OP_SPARE_B],
                 checked, cycles);
        $display("%0d failures, %0d left outstanding.", fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
